FILE: design/clnl_pkg.sv
package clnl_pkg;

  // Input word: one source byte or the end-of-text mark
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } text_word_t;

  // Output word: one token
  typedef struct packed {
    logic [3:0]  token_kind;
    logic [31:0] literal_value;
    logic        too_big;
    logic [19:0] start_line;
    logic [11:0] start_column;
    logic [7:0]  char_out;
    logic        last;
  } token_word_t;

  // Up to two tokens produced by one input word
  typedef struct packed {
    logic [1:0]            count;
    token_word_t [1:0]     word;
  } token_pair_t;

  typedef enum logic [13:0] {
    M_IDLE      = 14'b00000000000001,
    M_SLASH     = 14'b00000000000010,
    M_LINECMT   = 14'b00000000000100,
    M_BLOCK     = 14'b00000000001000,
    M_BLOCKSTAR = 14'b00000000010000,
    M_ZERO      = 14'b00000000100000,
    M_HEXSTART  = 14'b00000001000000,
    M_NUM       = 14'b00000010000000,
    M_SUF_U     = 14'b00000100000000,
    M_SUF_L     = 14'b00001000000000,
    M_FRAC      = 14'b00010000000000,
    M_EXPSTART  = 14'b00100000000000,
    M_EXPSIGN   = 14'b01000000000000,
    M_EXPDIG    = 14'b10000000000000
  } scan_mode_t;

  typedef enum logic [1:0] {
    BASE_DEC = 2'd0,
    BASE_OCT = 2'd1,
    BASE_HEX = 2'd2
  } base_t;

  // Integer suffix classes; the code doubles as the token kind
  localparam logic [2:0] SFX_PLAIN = 3'd0;
  localparam logic [2:0] SFX_U     = 3'd1;
  localparam logic [2:0] SFX_L     = 3'd2;
  localparam logic [2:0] SFX_UL    = 3'd3;
  localparam logic [2:0] SFX_LL    = 3'd4;
  localparam logic [2:0] SFX_ULL   = 3'd5;

  localparam logic [3:0] KIND_FLOAT   = 4'd6;
  localparam logic [3:0] KIND_DOUBLE  = 4'd7;
  localparam logic [3:0] KIND_LDOUBLE = 4'd8;
  localparam logic [3:0] KIND_OTHER   = 4'd9;
  localparam logic [3:0] KIND_NO_HEX  = 4'd10;
  localparam logic [3:0] KIND_OPEN    = 4'd11;
  localparam logic [3:0] KIND_END     = 4'd12;
  localparam logic [3:0] KIND_NO_EXP  = 4'd13;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  // lower-case letters; (c | CASE_BIT) folds the upper-case form onto them
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_E  = 8'h65;
  localparam logic [7:0] CH_LO_F  = 8'h66;
  localparam logic [7:0] CH_LO_L  = 8'h6C;
  localparam logic [7:0] CH_LO_U  = 8'h75;
  localparam logic [7:0] CH_LO_X  = 8'h78;

  localparam int QUEUE_DEPTH = 4;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lo;
    lo = c | CASE_BIT;
    if (is_dec(c)) return {1'b1, c[3:0]};
    else if ((lo >= CH_LO_A) && (lo <= CH_LO_F)) return {1'b1, lo[3:0] + 4'd9};
    else return 5'd0;
  endfunction

  function automatic token_word_t make_word(input logic [3:0] kind,
                                            input logic [31:0] value,
                                            input logic big,
                                            input logic [19:0] line,
                                            input logic [11:0] col,
                                            input logic [7:0] ch);
    token_word_t w;
    w.token_kind    = kind;
    w.literal_value = value;
    w.too_big       = big;
    w.start_line    = line;
    w.start_column  = col;
    w.char_out      = ch;
    w.last          = 1'b0;
    return w;
  endfunction

endpackage

FILE: design/c_numeric_literal_lexer.sv
// Channel | Direction | Handshake                | Word
// text    | in        | text_valid / text_stall  | char_code, end_of_input
// token   | out       | token_valid / token_stall | one token, last marks final of a byte
//
// One source byte is taken per cycle while text_stall is low; the scanner state updates
// in the cycle the byte is taken and its tokens (zero, one or two) land in a four-entry
// token queue. text_stall rises while the queue has fewer than two free slots, so
// two-token bytes slow intake to the output's one-token-per-cycle drain when not stalled.
// Reset (rst, synchronous) empties the queue and returns the scanner to line 1, column 0.
module c_numeric_literal_lexer #(
  parameter int VALUE_BITS  = 32,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  text_valid,
  output logic                  text_stall,
  input  clnl_pkg::text_word_t  text,
  output logic                  token_valid,
  input  logic                  token_stall,
  output clnl_pkg::token_word_t token
);
  import clnl_pkg::*;

  logic        accept;
  logic        room;
  token_pair_t tokens;

  assign text_stall = !room;
  assign accept     = text_valid && room;

  clnl_scan #(
    .VALUE_BITS (VALUE_BITS),
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_scan (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .text  (text),
    .tokens(tokens)
  );

  clnl_resq u_resq (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .tokens     (tokens),
    .room       (room),
    .token_valid(token_valid),
    .token_stall(token_stall),
    .token      (token)
  );

endmodule

FILE: design/clnl_scan.sv
module clnl_scan #(
  parameter int VALUE_BITS  = 32,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  clnl_pkg::text_word_t  text,
  output clnl_pkg::token_pair_t tokens
);
  import clnl_pkg::*;

  localparam int PROD_BITS = VALUE_BITS + 4;

  scan_mode_t             mode, mode_next;
  logic [VALUE_BITS-1:0]  acc, acc_next;
  logic                   ovf, ovf_next;
  base_t                  base, base_next;
  logic [2:0]             suffix, suffix_next;
  logic [LINE_BITS-1:0]   line_count, line_next;
  logic [COLUMN_BITS-1:0] col_count, col_next;
  logic [LINE_BITS-1:0]   tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0] tok_col, tok_col_next;

  logic [7:0]             c;
  logic [7:0]             c_lo;
  logic [4:0]             hex;
  logic                   run_idle, run_num, push_en;
  logic [3:0]             push_digit;
  logic [PROD_BITS-1:0]   acc_wide, prod;
  logic                   e0_valid, e1_valid;
  token_word_t            e0, e1;
  logic [31:0]            acc_out;
  logic [19:0]            tline_out, line_out;
  logic [11:0]            tcol_out, col_out;

  assign c         = text.char_code;
  assign c_lo      = text.char_code | CASE_BIT;
  assign hex       = hex_digit(text.char_code);
  assign acc_out   = 32'(acc);
  assign tline_out = 20'(tok_line);
  assign tcol_out  = 12'(tok_col);
  assign line_out  = 20'(line_count);
  assign col_out   = 12'(col_count);
  assign acc_wide  = PROD_BITS'(acc);

  always_comb begin
    mode_next     = mode;
    acc_next      = acc;
    ovf_next      = ovf;
    base_next     = base;
    suffix_next   = suffix;
    line_next     = line_count;
    col_next      = col_count;
    tok_line_next = tok_line;
    tok_col_next  = tok_col;
    run_idle      = 1'b0;
    run_num       = 1'b0;
    push_en       = 1'b0;
    push_digit    = 4'd0;
    prod          = '0;
    e0_valid      = 1'b0;
    e0            = '0;
    e1_valid      = 1'b0;
    e1            = '0;

    if (text.end_of_input) begin
      unique case (mode)
        M_SLASH: begin
          e0_valid = 1'b1;
          e0 = make_word(KIND_OTHER, 32'd0, 1'b0, tline_out, tcol_out, CH_SLASH);
        end
        M_BLOCK, M_BLOCKSTAR: begin
          e0_valid = 1'b1;
          e0 = make_word(KIND_OPEN, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
        end
        M_ZERO, M_NUM, M_SUF_U, M_SUF_L: begin
          e0_valid = 1'b1;
          e0 = make_word({1'b0, suffix}, acc_out, ovf, tline_out, tcol_out, 8'd0);
        end
        M_HEXSTART: begin
          e0_valid = 1'b1;
          e0 = make_word(KIND_NO_HEX, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
        end
        M_FRAC, M_EXPDIG: begin
          e0_valid = 1'b1;
          e0 = make_word(KIND_DOUBLE, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
        end
        M_EXPSTART, M_EXPSIGN: begin
          e0_valid = 1'b1;
          e0 = make_word(KIND_NO_EXP, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
        end
        default: ;
      endcase
      e1_valid      = 1'b1;
      e1            = make_word(KIND_END, 32'd0, 1'b0, line_out, col_out, 8'd0);
      // back to the reset state
      mode_next     = M_IDLE;
      acc_next      = '0;
      ovf_next      = 1'b0;
      base_next     = BASE_DEC;
      suffix_next   = SFX_PLAIN;
      line_next     = LINE_BITS'(1);
      col_next      = '0;
      tok_line_next = '0;
      tok_col_next  = '0;
    end else begin
      unique case (mode)
        M_SLASH: begin
          if (c == CH_SLASH) mode_next = M_LINECMT;
          else if (c == CH_STAR) mode_next = M_BLOCK;
          else begin
            e0_valid = 1'b1;
            e0 = make_word(KIND_OTHER, 32'd0, 1'b0, tline_out, tcol_out, CH_SLASH);
            run_idle = 1'b1;
          end
        end
        M_LINECMT: begin
          if (c == CH_LF) mode_next = M_IDLE;
        end
        M_BLOCK: begin
          if (c == CH_STAR) mode_next = M_BLOCKSTAR;
        end
        M_BLOCKSTAR: begin
          if (c == CH_SLASH) mode_next = M_IDLE;
          else if (c != CH_STAR) mode_next = M_BLOCK;
        end
        M_ZERO: begin
          if (c_lo == CH_LO_X) begin
            base_next = BASE_HEX;
            mode_next = M_HEXSTART;
          end else begin
            mode_next = M_NUM;
            run_num   = 1'b1;
          end
        end
        M_HEXSTART: begin
          if (hex[4]) begin
            mode_next = M_NUM;
            run_num   = 1'b1;
          end else begin
            e0_valid = 1'b1;
            e0 = make_word(KIND_NO_HEX, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
            run_idle = 1'b1;
          end
        end
        M_NUM: run_num = 1'b1;
        M_SUF_U: begin
          if (c_lo == CH_LO_L) begin
            suffix_next = SFX_UL;
            mode_next   = M_SUF_L;
          end else begin
            e0_valid = 1'b1;
            e0 = make_word({1'b0, suffix}, acc_out, ovf, tline_out, tcol_out, 8'd0);
            run_idle = 1'b1;
          end
        end
        M_SUF_L: begin
          if (c_lo == CH_LO_L) begin
            suffix_next = (suffix == SFX_UL) ? SFX_ULL : SFX_LL;
            mode_next   = M_IDLE;
            e0_valid    = 1'b1;
            e0 = make_word({1'b0, suffix_next}, acc_out, ovf, tline_out, tcol_out, 8'd0);
          end else begin
            e0_valid = 1'b1;
            e0 = make_word({1'b0, suffix}, acc_out, ovf, tline_out, tcol_out, 8'd0);
            run_idle = 1'b1;
          end
        end
        M_FRAC, M_EXPDIG: begin
          if (c_lo == CH_LO_E && mode == M_FRAC) mode_next = M_EXPSTART;
          else if (!is_dec(c)) begin
            // end of float: an f or l suffix is swallowed
            e0_valid = 1'b1;
            mode_next = M_IDLE;
            if (c_lo == CH_LO_F)
              e0 = make_word(KIND_FLOAT, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
            else if (c_lo == CH_LO_L)
              e0 = make_word(KIND_LDOUBLE, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
            else begin
              e0 = make_word(KIND_DOUBLE, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
              run_idle = 1'b1;
            end
          end
        end
        M_EXPSTART, M_EXPSIGN: begin
          if (is_dec(c)) mode_next = M_EXPDIG;
          else if ((c == CH_PLUS || c == CH_MINUS) && mode == M_EXPSTART)
            mode_next = M_EXPSIGN;
          else begin
            e0_valid  = 1'b1;
            e0 = make_word(KIND_NO_EXP, 32'd0, 1'b0, tline_out, tcol_out, 8'd0);
            mode_next = M_IDLE;
            if (c_lo != CH_LO_F && c_lo != CH_LO_L) run_idle = 1'b1;
          end
        end
        default: run_idle = 1'b1;
      endcase

      if (run_num) begin
        priority if (base == BASE_HEX && hex[4]) begin
          push_en    = 1'b1;
          push_digit = hex[3:0];
          prod       = (acc_wide << 4) + PROD_BITS'(push_digit);
        end else if (base == BASE_OCT && c >= CH_ZERO && c <= CH_SEVEN) begin
          push_en    = 1'b1;
          push_digit = c[3:0];
          prod       = (acc_wide << 3) + PROD_BITS'(push_digit);
        end else if (base == BASE_DEC && is_dec(c)) begin
          push_en    = 1'b1;
          push_digit = c[3:0];
          prod       = (acc_wide << 3) + (acc_wide << 1) + PROD_BITS'(push_digit);
        end else if (base != BASE_HEX && c == CH_DOT) begin
          mode_next = M_FRAC;
        end else if (base != BASE_HEX && c_lo == CH_LO_E) begin
          mode_next = M_EXPSTART;
        end else if (c_lo == CH_LO_U) begin
          suffix_next = SFX_U;
          mode_next   = M_SUF_U;
        end else if (c_lo == CH_LO_L) begin
          suffix_next = SFX_L;
          mode_next   = M_SUF_L;
        end else begin
          e0_valid = 1'b1;
          e0 = make_word({1'b0, suffix}, acc_out, ovf, tline_out, tcol_out, 8'd0);
          run_idle = 1'b1;
        end
        if (push_en) begin
          acc_next = prod[VALUE_BITS-1:0];
          if (prod[PROD_BITS-1:VALUE_BITS] != '0) ovf_next = 1'b1;
        end
      end

      if (run_idle) begin
        mode_next = M_IDLE;
        priority if (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_SPACE ||
                     c == CH_CR || c == CH_LF) begin
          mode_next = M_IDLE;
        end else if (c == CH_SLASH) begin
          tok_line_next = line_count;
          tok_col_next  = col_count;
          mode_next     = M_SLASH;
        end else if (c == CH_HASH) begin
          mode_next = M_LINECMT;
        end else if (is_dec(c)) begin
          tok_line_next = line_count;
          tok_col_next  = col_count;
          ovf_next      = 1'b0;
          suffix_next   = SFX_PLAIN;
          if (c == CH_ZERO) begin
            acc_next  = '0;
            base_next = BASE_OCT;
            mode_next = M_ZERO;
          end else begin
            acc_next  = VALUE_BITS'(c[3:0]);
            base_next = BASE_DEC;
            mode_next = M_NUM;
          end
        end else begin
          tok_line_next = line_count;
          tok_col_next  = col_count;
          e1_valid      = 1'b1;
          e1 = make_word(KIND_OTHER, 32'd0, 1'b0, line_out, col_out, c);
        end
      end

      if (c == CH_LF) begin
        line_next = line_count + LINE_BITS'(1);
        col_next  = '0;
      end else if (col_count != '1) begin
        col_next = col_count + COLUMN_BITS'(1);
      end
    end
  end

  // pack the tokens so the first one always sits in slot 0
  always_comb begin
    tokens.count   = 2'(e0_valid) + 2'(e1_valid);
    tokens.word[0] = e0_valid ? e0 : e1;
    tokens.word[1] = e1;
    tokens.word[0].last = !(e0_valid && e1_valid);
    tokens.word[1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      acc        <= '0;
      ovf        <= 1'b0;
      base       <= BASE_DEC;
      suffix     <= SFX_PLAIN;
      line_count <= LINE_BITS'(1);
      col_count  <= '0;
      tok_line   <= '0;
      tok_col    <= '0;
    end else if (accept) begin
      mode       <= mode_next;
      acc        <= acc_next;
      ovf        <= ovf_next;
      base       <= base_next;
      suffix     <= suffix_next;
      line_count <= line_next;
      col_count  <= col_next;
      tok_line   <= tok_line_next;
      tok_col    <= tok_col_next;
    end
  end

endmodule

FILE: design/clnl_resq.sv
module clnl_resq (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  clnl_pkg::token_pair_t tokens,
  output logic                  room,
  output logic                  token_valid,
  input  logic                  token_stall,
  output clnl_pkg::token_word_t token
);
  import clnl_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  token_word_t         mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] head, tail;
  logic [CNT_BITS-1:0] count, count_next;
  logic [1:0]          n_push;
  logic                pop;

  assign n_push      = push ? tokens.count : 2'd0;
  assign pop         = token_valid && !token_stall;
  assign token_valid = (count != '0);
  assign token       = mem[head];
  // an input word may bring two tokens
  assign room        = (count <= CNT_BITS'(QUEUE_DEPTH - 2));
  assign count_next  = count + CNT_BITS'(n_push) - CNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem[tail] <= tokens.word[0];
    if (n_push == 2'd2) mem[tail + PTR_BITS'(1)] <= tokens.word[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      head  <= head + PTR_BITS'(pop);
      tail  <= tail + PTR_BITS'(n_push);
      count <= count_next;
    end
  end

endmodule
